// ===== sv/ipv4_rnh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_rnh_pkg
// Types and codes shared by the IPv4 next-hop lookup block: request and
// result items, route table entry layout, request and register codes, states.
// ----------------------------------------------------------------------------
package ipv4_rnh_pkg;

    // request codes
    localparam logic [1:0] REQ_ROUTE_WR = 2'd0;
    localparam logic [1:0] REQ_LOCAL_WR = 2'd1;
    localparam logic [1:0] REQ_LOOKUP   = 2'd2;

    // configuration register indexes
    localparam logic CFG_LB_EN = 1'b0;
    localparam logic CFG_LB_IF = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  entry_index;
        logic [31:0] route_dest;
        logic [31:0] route_netmask;
        logic [31:0] route_gateway;
        logic [7:0]  route_interface;
        logic        entry_valid;
        logic [31:0] local_address;
        logic [31:0] lookup_dest;
    } t_req_in;

    typedef struct packed {
        logic        route_found;
        logic [3:0]  matched_slot;
        logic [31:0] hop_addr;
        logic [7:0]  out_interface;
        logic        is_loopback;
    } t_res_out;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [7:0]  ifc;
    } t_route_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUTE,
        ST_LOCAL,
        ST_RESP
    } t_state;

endpackage
`default_nettype wire

// ===== sv/ipv4_route_next_hop_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_route_next_hop_lookup
// Routing table and local address table held in synchronous memories; a
// lookup scans routes from the highest slot down, then local addresses.
// ----------------------------------------------------------------------------
// Usage: request items enter on i_in / i_in_valid / o_in_ready and are either
// a route write, a local address write or a lookup. Every request item gives
// exactly one result item on o_out / o_out_valid / i_out_ready (all zero for
// writes, misses and unknown codes). The loopback registers are written
// through i_cfg_we / i_cfg_index / i_cfg_data; the user must write them
// only while no item is in flight, as the block itself does not enforce it.
// One item is handled at a time. A write goes from ST_IDLE to ST_RESP, which
// loads the output register. A lookup reads one route slot per cycle from the
// route memory, highest slot first, and stops at the first hit. Without a
// loopback interface a hit then reads the local address memory one slot per
// cycle, stopping at the first match or the last slot. ST_RESP then loads the
// output register. The next item is taken the cycle after the result is
// loaded, even if the receiver has not taken it yet; a further result waits
// while the output register stays full. Reset clears all valid bits and both
// registers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv4_route_next_hop_lookup #(
    parameter int ROUTE_ENTRIES = 16,
    parameter int LOCAL_ENTRIES = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ipv4_rnh_pkg::t_req_in  i_in,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    output ipv4_rnh_pkg::t_res_out      o_out,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_index,
    input  wire logic [7:0]             i_cfg_data
);

    localparam int RW  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int LW  = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
    localparam int RIW = (RW > 4) ? RW : 4;
    localparam int LIW = (LW > 4) ? LW : 4;
    localparam logic [RW-1:0] R_LAST = RW'(ROUTE_ENTRIES - 1);
    localparam logic [LW-1:0] L_LAST = LW'(LOCAL_ENTRIES - 1);

    // memories
    ipv4_rnh_pkg::t_route_entry route_mem [ROUTE_ENTRIES];
    logic [31:0]                local_mem [LOCAL_ENTRIES];

    ipv4_rnh_pkg::t_state       r_state, n_state;
    ipv4_rnh_pkg::t_route_entry r_route_q;
    logic [31:0]                r_local_q;
    logic [RW-1:0]              r_slot;
    logic [LW-1:0]              r_lslot;
    logic [ROUTE_ENTRIES-1:0]   r_route_vld;
    logic [LOCAL_ENTRIES-1:0]   r_local_vld;
    logic [31:0]                r_addr;
    ipv4_rnh_pkg::t_res_out     r_res;
    ipv4_rnh_pkg::t_res_out     r_out;
    logic                       r_out_valid;
    logic                       r_lb_en;
    logic [7:0]                 r_lb_if;

    logic                       w_accept;
    logic                       w_load;
    logic [RW-1:0]              w_route_raddr;
    logic [LW-1:0]              w_local_raddr;
    logic [RIW-1:0]             w_ridx;
    logic [LIW-1:0]             w_lidx;
    logic [RIW-1:0]             w_slot_ext;
    logic                       w_route_we;
    logic                       w_local_we;
    logic                       w_route_hit;
    logic                       w_local_hit;
    logic [31:0]                w_hop;
    ipv4_rnh_pkg::t_route_entry w_wr_entry;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ridx     = RIW'(i_in.entry_index);
    assign w_lidx     = LIW'(i_in.entry_index);
    assign w_slot_ext = RIW'(r_slot);

    // slots beyond the table depth are ignored
    assign w_route_we = w_accept && (i_in.req_type == ipv4_rnh_pkg::REQ_ROUTE_WR)
                        && ({1'b0, w_ridx} < (RIW + 1)'(ROUTE_ENTRIES));
    assign w_local_we = w_accept && (i_in.req_type == ipv4_rnh_pkg::REQ_LOCAL_WR)
                        && ({1'b0, w_lidx} < (LIW + 1)'(LOCAL_ENTRIES));

    assign w_wr_entry.dest    = i_in.route_dest;
    assign w_wr_entry.mask    = i_in.route_netmask;
    assign w_wr_entry.gateway = i_in.route_gateway;
    assign w_wr_entry.ifc     = i_in.route_interface;

    // route slot r_slot is in r_route_q; dest of zero matches everything
    assign w_route_hit = r_route_vld[r_slot]
        && (((r_route_q.dest & r_route_q.mask) == (r_addr & r_route_q.mask))
            || (r_route_q.dest == '0));
    assign w_hop = (r_route_q.gateway == '0) ? r_route_q.dest : r_route_q.gateway;
    assign w_local_hit = r_local_vld[r_lslot] && (r_local_q == r_res.hop_addr);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipv4_rnh_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.req_type == ipv4_rnh_pkg::REQ_LOOKUP) begin
                        n_state = ipv4_rnh_pkg::ST_ROUTE;
                    end else begin
                        n_state = ipv4_rnh_pkg::ST_RESP;
                    end
                end
            end
            ipv4_rnh_pkg::ST_ROUTE: begin
                if (w_route_hit) begin
                    n_state = r_lb_en ? ipv4_rnh_pkg::ST_RESP : ipv4_rnh_pkg::ST_LOCAL;
                end else if (r_slot == '0) begin
                    n_state = ipv4_rnh_pkg::ST_RESP;
                end
            end
            ipv4_rnh_pkg::ST_LOCAL: begin
                if (w_local_hit || (r_lslot == L_LAST)) begin
                    n_state = ipv4_rnh_pkg::ST_RESP;
                end
            end
            ipv4_rnh_pkg::ST_RESP: begin
                if (w_load) begin
                    n_state = ipv4_rnh_pkg::ST_IDLE;
                end
            end
            default: n_state = ipv4_rnh_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_in_ready    = (r_state == ipv4_rnh_pkg::ST_IDLE);
        w_load        = (r_state == ipv4_rnh_pkg::ST_RESP) && (!r_out_valid || i_out_ready);
        w_route_raddr = R_LAST;
        w_local_raddr = '0;
        unique case (r_state)
            ipv4_rnh_pkg::ST_ROUTE: begin
                w_route_raddr = (r_slot == '0) ? R_LAST : (r_slot - 1'b1);
            end
            ipv4_rnh_pkg::ST_LOCAL: begin
                w_local_raddr = (r_lslot == L_LAST) ? '0 : (r_lslot + 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipv4_rnh_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_route_vld <= '0;
            r_local_vld <= '0;
            r_lb_en     <= 1'b0;
            r_lb_if     <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_route_we) begin
                r_route_vld[w_ridx[RW-1:0]] <= i_in.entry_valid;
            end
            if (w_local_we) begin
                r_local_vld[w_lidx[LW-1:0]] <= i_in.entry_valid;
            end
            if (i_cfg_we) begin
                priority case (i_cfg_index)
                    ipv4_rnh_pkg::CFG_LB_EN: r_lb_en <= i_cfg_data[0];
                    ipv4_rnh_pkg::CFG_LB_IF: r_lb_if <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // route memory
    always_ff @(posedge i_clk) begin
        if (w_route_we) begin
            route_mem[w_ridx[RW-1:0]] <= w_wr_entry;
        end
        r_route_q <= route_mem[w_route_raddr];
    end

    // local address memory
    always_ff @(posedge i_clk) begin
        if (w_local_we) begin
            local_mem[w_lidx[LW-1:0]] <= i_in.local_address;
        end
        r_local_q <= local_mem[w_local_raddr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_slot  <= w_route_raddr;
        r_lslot <= w_local_raddr;
        if (w_accept) begin
            r_addr <= i_in.lookup_dest;
            r_res  <= '0;
        end
        if ((r_state == ipv4_rnh_pkg::ST_ROUTE) && w_route_hit) begin
            r_res.route_found   <= 1'b1;
            r_res.matched_slot  <= w_slot_ext[3:0];
            r_res.hop_addr      <= w_hop;
            r_res.out_interface <= r_route_q.ifc;
            r_res.is_loopback   <= r_lb_en && (r_route_q.ifc == r_lb_if);
        end
        if ((r_state == ipv4_rnh_pkg::ST_LOCAL) && w_local_hit) begin
            r_res.is_loopback <= 1'b1;
        end
        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ipv4_rnh_pkg::ST_IDLE))
        else $error("accepted item did not start work");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ipv4_rnh_pkg::ST_RESP))
        else $error("result item appeared outside the response state");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.route_found) |-> ((o_out.hop_addr == '0)
            && (o_out.out_interface == '0) && !o_out.is_loopback
            && (o_out.matched_slot == '0)))
        else $error("miss or write result carries nonzero fields");

    a_local_scan_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ipv4_rnh_pkg::ST_ROUTE) && (n_state == ipv4_rnh_pkg::ST_LOCAL))
            |=> r_res.route_found)
        else $error("local address scan started without a route hit");
`endif

endmodule
`default_nettype wire

// ===== tb/ipv4_rnh_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_rnh_checker
// Watches the request, result and register ports of the next-hop lookup
// block, keeps its own copy of the route and local address tables, predicts
// one result item per accepted request item and compares results in order.
// ----------------------------------------------------------------------------
module ipv4_rnh_checker #(
    parameter int ROUTE_ENTRIES = 16,
    parameter int LOCAL_ENTRIES = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire ipv4_rnh_pkg::t_req_in  i_req,
    input  wire logic                   i_req_valid,
    input  wire logic                   i_req_ready,
    input  wire ipv4_rnh_pkg::t_res_out i_res,
    input  wire logic                   i_res_valid,
    input  wire logic                   i_res_ready,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_index,
    input  wire logic [7:0]             i_cfg_data,
    output int                          o_errors,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4_rnh_pkg::*;

    t_route_entry routes    [ROUTE_ENTRIES];
    logic         route_ok  [ROUTE_ENTRIES];
    logic [31:0]  locals    [LOCAL_ENTRIES];
    logic         local_ok  [LOCAL_ENTRIES];
    logic         lb_en;
    logic [7:0]   lb_ifc;

    t_res_out     hop_q [$];
    t_res_out     want;
    int           errors = 0;

    assign o_errors = errors;

    // applies one request item to the tables and returns the result it gives
    function automatic t_res_out route_request(input t_req_in r);
        t_res_out    res;
        logic [31:0] hop;
        logic        hit;
        t_route_entry e;
        res = '0;
        hit = 1'b0;
        case (r.req_type)
            REQ_ROUTE_WR: begin
                if (r.entry_index < ROUTE_ENTRIES) begin
                    routes[r.entry_index]   = '{dest: r.route_dest, mask: r.route_netmask,
                                                gateway: r.route_gateway,
                                                ifc: r.route_interface};
                    route_ok[r.entry_index] = r.entry_valid;
                end
            end
            REQ_LOCAL_WR: begin
                if (r.entry_index < LOCAL_ENTRIES) begin
                    locals[r.entry_index]   = r.local_address;
                    local_ok[r.entry_index] = r.entry_valid;
                end
            end
            REQ_LOOKUP: begin
                // highest valid matching slot wins; dest 0 matches anything
                for (int s = ROUTE_ENTRIES - 1; s >= 0 && !hit; s--) begin
                    e = routes[s];
                    if (route_ok[s] && (((e.dest & e.mask) == (r.lookup_dest & e.mask)) ||
                                        (e.dest == 32'd0))) begin
                        hit = 1'b1;
                        hop = (e.gateway == 32'd0) ? e.dest : e.gateway;
                        res.route_found   = 1'b1;
                        res.matched_slot  = 4'(s);
                        res.hop_addr      = hop;
                        res.out_interface = e.ifc;
                        if (lb_en) begin
                            res.is_loopback = (e.ifc == lb_ifc);
                        end else begin
                            for (int k = 0; k < LOCAL_ENTRIES; k++) begin
                                if (local_ok[k] && locals[k] == hop) res.is_loopback = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ROUTE_ENTRIES; s++) begin
                routes[s]   = '0;
                route_ok[s] = 1'b0;
            end
            for (int k = 0; k < LOCAL_ENTRIES; k++) begin
                locals[k]   = '0;
                local_ok[k] = 1'b0;
            end
            lb_en  = 1'b0;
            lb_ifc = '0;
            hop_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LB_EN) lb_en = i_cfg_data[0];
                else lb_ifc = i_cfg_data;
            end
            if (i_res_valid && i_res_ready) begin
                if (hop_q.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: result item with nothing expected: ", $realtime,
                                 "found=%0d slot=%0d hop=%h ifc=%h loop=%0d",
                                 i_res.route_found, i_res.matched_slot,
                                 i_res.hop_addr, i_res.out_interface, i_res.is_loopback);
                    errors++;
                end else begin
                    want = hop_q.pop_front();
                    if (want.route_found   !== i_res.route_found  ||
                        want.matched_slot  !== i_res.matched_slot ||
                        want.hop_addr      !== i_res.hop_addr     ||
                        want.out_interface !== i_res.out_interface ||
                        want.is_loopback   !== i_res.is_loopback) begin
                        if (errors < 10)
                            $display("%0t: mismatch ", $realtime,
                                     "exp found=%0d slot=%0d hop=%h ifc=%h loop=%0d ",
                                     want.route_found, want.matched_slot,
                                     want.hop_addr, want.out_interface, want.is_loopback,
                                     "got found=%0d slot=%0d hop=%h ifc=%h loop=%0d",
                                     i_res.route_found, i_res.matched_slot, i_res.hop_addr,
                                     i_res.out_interface, i_res.is_loopback);
                        errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) hop_q.push_back(route_request(i_req));
            o_pending <= hop_q.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_ipv4_route_next_hop_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ipv4_route_next_hop_lookup
// Drives route writes, local address writes, lookups and unused request codes
// into the next-hop lookup block under several loopback settings and idle
// patterns; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ipv4_route_next_hop_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4_rnh_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         PHASES       = 8;
    localparam int         PHASE_ITEMS  = 219;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    t_req_in    req       = '0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    t_res_out   res;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data  = '0;

    int errors;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // what the stimulus has written so far, used to aim lookups and addresses
    bit [31:0] sh_dest  [16];
    bit [31:0] sh_mask  [16];
    bit [31:0] sh_hop   [16];
    bit [31:0] sh_local [8];
    bit [7:0]  sh_lb_ifc;

    ipv4_route_next_hop_lookup dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (req),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .o_out       (res),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ipv4_rnh_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_res       (res),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("ipv4_route_next_hop_lookup test failed");
        $finish;
    end

    function automatic t_req_in noise_req();
        t_req_in r;
        r.req_type        = 2'($urandom);
        r.entry_index     = 4'($urandom);
        r.route_dest      = $urandom;
        r.route_netmask   = $urandom;
        r.route_gateway   = $urandom;
        r.route_interface = 8'($urandom);
        r.entry_valid     = 1'($urandom);
        r.local_address   = $urandom;
        r.lookup_dest     = $urandom;
        return r;
    endfunction

    function automatic t_req_in route_wr(input logic [3:0] idx, input logic [31:0] dest,
                                         input logic [31:0] mask, input logic [31:0] gw,
                                         input logic [7:0] ifc, input logic v);
        t_req_in r;
        r = noise_req();
        r.req_type        = REQ_ROUTE_WR;
        r.entry_index     = idx;
        r.route_dest      = dest;
        r.route_netmask   = mask;
        r.route_gateway   = gw;
        r.route_interface = ifc;
        r.entry_valid     = v;
        sh_dest[idx] = dest;
        sh_mask[idx] = mask;
        sh_hop[idx]  = (gw == 32'd0) ? dest : gw;
        return r;
    endfunction

    function automatic t_req_in local_wr(input logic [3:0] idx, input logic [31:0] addr,
                                         input logic v);
        t_req_in r;
        r = noise_req();
        r.req_type      = REQ_LOCAL_WR;
        r.entry_index   = idx;
        r.local_address = addr;
        r.entry_valid   = v;
        if (idx < 8) sh_local[idx[2:0]] = addr;
        return r;
    endfunction

    function automatic t_req_in lookup(input logic [31:0] addr);
        t_req_in r;
        r = noise_req();
        r.req_type    = REQ_LOOKUP;
        r.lookup_dest = addr;
        return r;
    endfunction

    function automatic t_req_in make_random_req();
        t_req_in     r;
        int          pick;
        int          plen;
        int          s;
        logic [31:0] mask;
        logic [31:0] dest;
        logic [31:0] gw;
        logic [31:0] addr;
        logic [7:0]  ifc;
        logic [3:0]  idx;
        pick = $urandom_range(99);
        if (pick < 25) begin
            // mostly prefix masks so lookups find hits
            plen = $urandom_range(32);
            mask = (plen == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - plen));
            if ($urandom_range(99) < 15) mask = $urandom;
            dest = $urandom;
            if ($urandom_range(99) < 50) dest = dest & mask;
            if ($urandom_range(99) < 10) dest = 32'd0;
            s = $urandom_range(99);
            if (s < 30) gw = 32'd0;
            else if (s < 50) gw = sh_local[$urandom_range(7)];
            else gw = $urandom;
            ifc = ($urandom_range(99) < 40) ? sh_lb_ifc : 8'($urandom);
            r = route_wr(4'($urandom), dest, mask, gw, ifc, ($urandom_range(99) < 85));
        end else if (pick < 40) begin
            idx  = ($urandom_range(99) < 85) ? 4'($urandom_range(7)) : 4'($urandom_range(15, 8));
            addr = ($urandom_range(99) < 40) ? sh_hop[$urandom_range(15)] : $urandom;
            r = local_wr(idx, addr, ($urandom_range(99) < 80));
        end else if (pick < 95) begin
            s    = $urandom_range(15);
            addr = $urandom;
            if ($urandom_range(99) < 70) addr = (sh_dest[s] & sh_mask[s]) | (addr & ~sh_mask[s]);
            r = lookup(addr);
        end else begin
            r = noise_req();
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    task automatic send(input t_req_in r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
    endtask

    // hold the sender until every result item is back
    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_loopback(input logic en, input logic [7:0] ifc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LB_IF;
        cfg_data  <= ifc;
        @(posedge clk);
        cfg_index <= CFG_LB_EN;
        cfg_data  <= {7'($urandom), en};
        @(posedge clk);
        cfg_we    <= 1'b0;
        sh_lb_ifc = ifc;
    endtask

    initial begin
        logic       ph_en;
        logic [7:0] ph_ifc;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send(lookup(32'hFFFF_FFFF));                          // empty table misses
        send(route_wr(4'd0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b1)); // any-address route
        send(lookup(32'hFFFF_FFFF));
        send(route_wr(4'd15, 32'hC0A8_0100, 32'hFFFF_FF00, 32'd0, 8'hFF, 1'b1));
        send(lookup(32'hC0A8_01FF));                          // direct, hop is route dest
        send(route_wr(4'd8, 32'h0A00_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 8'h5A, 1'b1));
        send(lookup(32'h0A12_3456));
        send(local_wr(4'd7, 32'hFFFF_FFFF, 1'b1));
        send(lookup(32'h0A00_0001));                          // hop is a local address
        send(local_wr(4'd8, 32'hFFFF_FFFF, 1'b1));            // slots past the local table
        send(local_wr(4'd15, 32'h0000_0000, 1'b1));
        send(local_wr(4'd7, 32'hFFFF_FFFF, 1'b0));
        send(lookup(32'h0A00_0001));
        begin
            t_req_in r;
            r = noise_req();
            r.req_type = REQ_UNUSED;
            send(r);
        end
        send(route_wr(4'd15, 32'hC0A8_0100, 32'hFFFF_FF00, 32'd0, 8'hFF, 1'b0));
        send(lookup(32'hC0A8_0101));                          // invalid slot falls through
        send(route_wr(4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hC0A8_0101, 8'h01, 1'b1));
        send(local_wr(4'd0, 32'hC0A8_0101, 1'b1));
        send(lookup(32'hFFFF_FFFF));
        send(lookup(32'h0000_0000));
        drain();
        set_loopback(1'b1, 8'h5A);
        send(lookup(32'h0A00_0001));                          // interface equals loopback
        send(lookup(32'hFFFF_FFFF));
        send(route_wr(4'd0, 32'd0, 32'd0, 32'd0, 8'h00, 1'b0));
        send(lookup(32'h7F00_0001));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin ph_en = 1'b0; ph_ifc = 8'h00; end
                1: begin ph_en = 1'b1; ph_ifc = 8'h00; end
                2: begin ph_en = 1'b1; ph_ifc = 8'hFF; end
                3: begin ph_en = 1'b0; ph_ifc = 8'hFF; end
                4: begin ph_en = 1'b1; ph_ifc = 8'($urandom); end
                5: begin ph_en = 1'b0; ph_ifc = 8'($urandom); end
                default: begin ph_en = 1'($urandom); ph_ifc = 8'($urandom); end
            endcase
            set_loopback(ph_en, ph_ifc);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 100) drain();
                send(make_random_req());
            end
            drain();
        end

        recv_stall_pct = 0;
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("ipv4_route_next_hop_lookup test passed");
        end else begin
            $display("ipv4_route_next_hop_lookup test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
